// ----- design/mds_pkg.sv -----
`default_nettype none

package mds_pkg;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic REQ_MOVE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LEFT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_TOP    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_WIDTH  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_HEIGHT = 4'd3;

   localparam int AGE_SPAN = 100;
   localparam int TW_W     = 7;
   localparam int PROD_W   = 24;
   localparam int Q_FRAC_W = 14;
   localparam int Q_ONE    = 16384;

endpackage

`default_nettype wire

// ----- design/mouse_delta_smoother_core.sv -----
// Smooths relative mouse motion for a frame-driven consumer. Move events (req_tuser 0) are
// dropped when the clip rectangle is enabled and the pointer lies outside it; otherwise the
// negated motion replaces the pending delta. A frame tick (req_tuser 1) stores the pending
// delta and time in a ring of HISTORY_DEPTH entries, forms the sum of deltas weighted by
// recency (halving per older entry) and by max(0, 100 - age_ms), divides by 100, by the
// depth and by 2**(HISTORY_DEPTH - 1), clamps to [-1, 1] and returns both axes in Q2.14.
// A move is taken and the block stays ready. A tick keeps the input off until its result
// is pushed: one history entry is read and multiplied per cycle, newest first, through a
// three stage walk, then each axis passes the ABS, LOAD, DIV and SIGN states, divided by
// a reciprocal multiplication by the constant divisor with rounding, and the PUSH state
// pushes the result. A finished result waits in the output register while new items are
// taken; a further tick waits before its push until that result has been taken.
`default_nettype none

module mouse_delta_smoother_core #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // pos_x, pos_y, move_dx, move_dy, time_ms
   input  wire logic [mds_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // axis_x, axis_y
   output logic [mds_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mds_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int ACC_W = HISTORY_DEPTH + 24;
   localparam int NUM_W = ACC_W + 15;
   localparam logic [NUM_W-1:0] DEN =
      NUM_W'(mds_pkg::AGE_SPAN * HISTORY_DEPTH) << (HISTORY_DEPTH - 1);
   localparam logic [NUM_W-1:0] DEN_HALF = DEN >> 1;
   localparam int DIV_C   = mds_pkg::AGE_SPAN * HISTORY_DEPTH;
   localparam int DIV_CW  = $clog2(DIV_C);
   localparam int DIV_M_W = mds_pkg::Q_FRAC_W + 1 + DIV_CW;
   localparam int RCP_K   = DIV_M_W + DIV_CW;
   localparam int RCP_W   = DIV_M_W + 2;
   localparam int PRD_W   = DIV_M_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_K) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ABS,
      ST_LOAD,
      ST_DIV,
      ST_SIGN,
      ST_PUSH
   } state_type;

   state_type                  state_ff, state_in;

   logic [15:0]                clip_left_ff, clip_top_ff, clip_width_ff, clip_height_ff;

   logic signed [15:0]         hist_dx_ff   [HISTORY_DEPTH];
   logic signed [15:0]         hist_dy_ff   [HISTORY_DEPTH];
   logic [31:0]                hist_time_ff [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0]   hist_vld_ff, hist_vld_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic signed [15:0]         pend_dx_ff, pend_dx_in, pend_dy_ff, pend_dy_in;

   logic [31:0]                now_ff, now_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]           iss_cnt_ff, iss_cnt_in;
   logic                       s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic [mds_pkg::TW_W-1:0]   s1_tw_ff, s1_tw_in;
   logic signed [15:0]         s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in;
   logic signed [mds_pkg::PROD_W-1:0] s2_px_ff, s2_px_in, s2_py_ff, s2_py_in;
   logic signed [ACC_W-1:0]    acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;

   logic                       axis_sel_ff, axis_sel_in;
   logic                       neg_ff, neg_in, sat_ff, sat_in;
   logic [ACC_W-1:0]           mag_ff, mag_in;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic [mds_pkg::Q_FRAC_W:0] q_ff, q_in;
   logic signed [15:0]         axis_x_ff, axis_x_in, axis_y_ff, axis_y_in;

   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [mds_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                       req_xfer, hist_we, issuing, in_clip, clip_on;
   logic [15:0]                pos_x, pos_y;
   logic signed [15:0]         move_dx, move_dy;
   logic [31:0]                time_ms, age;
   logic [16:0]                lim_x, lim_y;
   logic signed [ACC_W-1:0]    acc_sel;
   logic signed [mds_pkg::PROD_W-1:0] tw_ext;
   logic [mds_pkg::Q_FRAC_W:0] q_mag;
   logic signed [15:0]         q_res;
   logic [DIV_M_W-1:0]         div_m;
   logic [PRD_W-1:0]           div_prod;

   assign pos_x   = req_tdata[15:0];
   assign pos_y   = req_tdata[31:16];
   assign move_dx = req_tdata[47:32];
   assign move_dy = req_tdata[63:48];
   assign time_ms = req_tdata[95:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign lim_x   = {1'b0, clip_left_ff} + {1'b0, clip_width_ff};
   assign lim_y   = {1'b0, clip_top_ff} + {1'b0, clip_height_ff};
   assign clip_on = (clip_width_ff != 16'd0) && (clip_height_ff != 16'd0);
   assign in_clip = (pos_x >= clip_left_ff) && ({1'b0, pos_x} < lim_x) &&
                    (pos_y >= clip_top_ff) && ({1'b0, pos_y} < lim_y);

   assign issuing = (state_ff == ST_WALK) && (iss_cnt_ff != CNT_W'(HISTORY_DEPTH));
   assign age     = now_ff - hist_time_ff[rd_idx_ff];
   assign tw_ext  = mds_pkg::PROD_W'({1'b0, s1_tw_ff});
   assign acc_sel = axis_sel_ff ? acc_y_ff : acc_x_ff;
   assign div_m    = DIV_M_W'(num_ff >> (HISTORY_DEPTH - 1));
   assign div_prod = {{RCP_W{1'b0}}, div_m} * {{DIV_M_W{1'b0}}, RCP};
   assign q_mag   = sat_ff ? (mds_pkg::Q_FRAC_W + 1)'(mds_pkg::Q_ONE) : q_ff;
   assign q_res   = neg_ff ? -16'(q_mag) : 16'(q_mag);

   always_comb begin
      state_in      = state_ff;
      hist_vld_in   = hist_vld_ff;
      hist_we       = 1'b0;
      slot_in       = slot_ff;
      pend_dx_in    = pend_dx_ff;
      pend_dy_in    = pend_dy_ff;
      now_in        = now_ff;
      rd_idx_in     = rd_idx_ff;
      iss_cnt_in    = iss_cnt_ff;
      s1_vld_in     = 1'b0;
      s1_tw_in      = s1_tw_ff;
      s1_dx_in      = s1_dx_ff;
      s1_dy_in      = s1_dy_ff;
      s2_vld_in     = s1_vld_ff;
      s2_px_in      = s1_dx_ff * tw_ext;
      s2_py_in      = s1_dy_ff * tw_ext;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      axis_sel_in   = axis_sel_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      mag_in        = mag_ff;
      num_in        = num_ff;
      q_in          = q_ff;
      axis_x_in     = axis_x_ff;
      axis_y_in     = axis_y_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (s2_vld_ff) begin
         acc_x_in = (acc_x_ff <<< 1) + ACC_W'(s2_px_ff);
         acc_y_in = (acc_y_ff <<< 1) + ACC_W'(s2_py_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tuser == mds_pkg::REQ_MOVE) begin
               if (!clip_on || in_clip) begin
                  pend_dx_in = (move_dx == 16'sh8000) ? 16'sh7fff : -move_dx;
                  pend_dy_in = (move_dy == 16'sh8000) ? 16'sh7fff : -move_dy;
               end
            end else if (req_xfer) begin
               hist_we              = 1'b1;
               hist_vld_in[slot_ff] = 1'b1;
               slot_in    = (slot_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               rd_idx_in  = slot_ff;
               pend_dx_in = '0;
               pend_dy_in = '0;
               now_in     = time_ms;
               iss_cnt_in = '0;
               acc_x_in   = '0;
               acc_y_in   = '0;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issuing) begin
               s1_vld_in  = 1'b1;
               s1_dx_in   = hist_vld_ff[rd_idx_ff] ? hist_dx_ff[rd_idx_ff] : '0;
               s1_dy_in   = hist_vld_ff[rd_idx_ff] ? hist_dy_ff[rd_idx_ff] : '0;
               s1_tw_in   = (hist_vld_ff[rd_idx_ff] && age < 32'(mds_pkg::AGE_SPAN)) ?
                            mds_pkg::TW_W'(32'(mds_pkg::AGE_SPAN) - age) : '0;
               rd_idx_in  = (rd_idx_ff == '0) ? IDX_W'(HISTORY_DEPTH - 1) : rd_idx_ff - 1'b1;
               iss_cnt_in = iss_cnt_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               axis_sel_in = 1'b0;
               state_in    = ST_ABS;
            end
         end
         ST_ABS: begin
            neg_in   = acc_sel[ACC_W-1];
            mag_in   = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            num_in   = (NUM_W'(mag_ff) << mds_pkg::Q_FRAC_W) + DEN_HALF;
            sat_in   = (NUM_W'(mag_ff) >= DEN);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q_in     = div_prod[RCP_K +: mds_pkg::Q_FRAC_W + 1];
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            if (!axis_sel_ff) begin
               axis_x_in   = q_res;
               axis_sel_in = 1'b1;
               state_in    = ST_ABS;
            end else begin
               axis_y_in = q_res;
               state_in  = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {axis_y_ff, axis_x_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= '0;
         clip_height_ff <= '0;
         hist_vld_ff    <= '0;
         slot_ff        <= '0;
         pend_dx_ff     <= '0;
         pend_dy_ff     <= '0;
         iss_cnt_ff     <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hist_vld_ff   <= hist_vld_in;
         slot_ff       <= slot_in;
         pend_dx_ff    <= pend_dx_in;
         pend_dy_ff    <= pend_dy_in;
         iss_cnt_ff    <= iss_cnt_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mds_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr_data;
               mds_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_data;
               mds_pkg::CSR_CLIP_WIDTH:  clip_width_ff  <= csr_data;
               mds_pkg::CSR_CLIP_HEIGHT: clip_height_ff <= csr_data;
               default: ;
            endcase
         end
         if (hist_we) begin
            hist_dx_ff[slot_ff]   <= pend_dx_ff;
            hist_dy_ff[slot_ff]   <= pend_dy_ff;
            hist_time_ff[slot_ff] <= time_ms;
         end
      end
      now_ff       <= now_in;
      rd_idx_ff    <= rd_idx_in;
      s1_tw_ff     <= s1_tw_in;
      s1_dx_ff     <= s1_dx_in;
      s1_dy_ff     <= s1_dy_in;
      s2_px_ff     <= s2_px_in;
      s2_py_ff     <= s2_py_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      axis_sel_ff  <= axis_sel_in;
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      mag_ff       <= mag_in;
      num_ff       <= num_in;
      q_ff         <= q_in;
      axis_x_ff    <= axis_x_in;
      axis_y_ff    <= axis_y_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

`default_nettype wire

// ----- design/mds_checker.sv -----
`default_nettype none

module mds_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [mds_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready
);

   logic signed [15:0] axis_x, axis_y;

   assign axis_x = rsp_tdata[15:0];
   assign axis_y = rsp_tdata[31:16];

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> axis_x <= mds_pkg::Q_ONE && axis_x >= -mds_pkg::Q_ONE &&
                     axis_y <= mds_pkg::Q_ONE && axis_y >= -mds_pkg::Q_ONE)
      else $error("axis outside clamp range");

   a_move_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == mds_pkg::REQ_MOVE |=> req_tready)
      else $error("move transfer stalled the input");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == mds_pkg::REQ_TICK |=> !req_tready)
      else $error("input ready during tick processing");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind mouse_delta_smoother_core mds_checker u_mds_checker (.*);

`default_nettype wire
